### rtl/core/assert_macros.svh
// assertion macros used by the dock frame planner rtl
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DFP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dock_frame_planner assertion failed");

// next-cycle implication, disabled while reset is held
`define DFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dock_frame_planner assertion failed");

`endif

### rtl/core/dfp_pkg.sv
// shared constants, codes and constant-divisor helpers for the dock frame planner
// no dependencies; used by the channel interfaces and the top level
package dfp_pkg;

  // frame and packet geometry
  localparam int HEADER_BYTES = 9;
  localparam int PACKET_BYTES = 7;

  // field widths
  localparam int FLEN_W = 9;
  localparam int HDR_W  = 32;
  localparam int NUM_W  = 16;
  localparam int BYTE_W = 8;
  localparam int BCD_W  = 28;
  localparam int MASK_W = 5;
  localparam int ACT_W  = 2;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // frame and packet byte codes
  localparam logic [HDR_W-1:0]  ID_HEADER  = 32'h0102_0304;
  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] CHARGE_CMD = 8'h04;
  localparam logic [BYTE_W-1:0] ADVERT_CMD = 8'h03;
  localparam logic [BYTE_W-1:0] HBEAT_CMD  = 8'h04;

  // result codes
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_CHARGE = 2'd1,
    ACT_SEND   = 2'd2
  } action_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // packet write masks: bits mark bytes one, two, three, four, six
  localparam logic [MASK_W-1:0] MASK_NONE    = 5'h00;
  localparam logic [MASK_W-1:0] MASK_ADVERT  = 5'h07;
  localparam logic [MASK_W-1:0] MASK_REBUILD = 5'h0F;
  localparam logic [MASK_W-1:0] MASK_DELAY   = 5'h10;

  // register indexes
  typedef enum logic [2:0] {
    REG_READY      = 3'd0,
    REG_ADVERTISED = 3'd1,
    REG_HB_LIMIT   = 3'd2,
    REG_THRESHOLD  = 3'd3,
    REG_LONG       = 3'd4,
    REG_SHORT      = 3'd5,
    REG_ADC        = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_READY      = 8'd0;
  localparam logic [BYTE_W-1:0] RST_ADVERTISED = 8'd1;
  localparam logic [BYTE_W-1:0] RST_HB_LIMIT   = 8'd10;
  localparam logic [BYTE_W-1:0] RST_THRESHOLD  = 8'd128;
  localparam logic [BYTE_W-1:0] RST_LONG       = 8'd0;
  localparam logic [BYTE_W-1:0] RST_SHORT      = 8'd0;
  localparam logic [BYTE_W-1:0] RST_ADC        = 8'd0;

  // reciprocal multipliers, exact for every 16-bit value
  localparam logic [16:0] RECIP_10    = 17'd52429;   // >> 19
  localparam logic [16:0] RECIP_100   = 17'd83887;   // >> 23
  localparam logic [16:0] RECIP_1000  = 17'd67109;   // >> 26
  localparam logic [16:0] RECIP_10000 = 17'd107375;  // >> 30

  // low nibble of x / 10
  function automatic logic [3:0] quo10_nib(input logic [NUM_W-1:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, RECIP_10};
    return p[22:19];
  endfunction

  // low nibble of x / 100
  function automatic logic [3:0] quo100_nib(input logic [NUM_W-1:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, RECIP_100};
    return p[26:23];
  endfunction

  // low nibble of x / 1000
  function automatic logic [3:0] quo1000_nib(input logic [NUM_W-1:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, RECIP_1000};
    return p[29:26];
  endfunction

  // x / 10000, at most six for a 16-bit value
  function automatic logic [3:0] quo10000_nib(input logic [NUM_W-1:0] x);
    logic [32:0] p;
    p = {17'd0, x} * {16'd0, RECIP_10000};
    return {1'b0, p[32:30]};
  endfunction

  // decimal digit from the low nibbles of q and q / 10: (q - 10 * (q / 10)) mod 16
  function automatic logic [3:0] dec_digit(input logic [3:0] hi, input logic [3:0] lo);
    logic [3:0] ten_hi;
    ten_hi = {hi[0], 3'b000} + {hi[2:0], 1'b0};
    return lo - ten_hi;
  endfunction

endpackage

### rtl/core/dfp_if.sv
// request channels of the dock frame planner: frame in, plan out
// depends on dfp_pkg for field widths
interface dfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dfp_pkg::FLEN_W-1:0]    frame_len;
  logic [dfp_pkg::HDR_W-1:0]     header_word;
  logic [dfp_pkg::NUM_W-1:0]     release_number;
  logic [dfp_pkg::NUM_W-1:0]     build_number;
  logic [dfp_pkg::BYTE_W-1:0]    accessory_byte;
  logic [dfp_pkg::BYTE_W-1:0]    mbox_ctrl;
  logic [dfp_pkg::BYTE_W-1:0]    packet_length;
  logic [dfp_pkg::BYTE_W-1:0]    packet_in_b4;
  logic [dfp_pkg::BYTE_W-1:0]    packet_in_b6;

  modport source (
    output valid, frame_len, header_word, release_number, build_number,
           accessory_byte, mbox_ctrl, packet_length, packet_in_b4, packet_in_b6,
    input  ready
  );
  modport sink (
    input  valid, frame_len, header_word, release_number, build_number,
           accessory_byte, mbox_ctrl, packet_length, packet_in_b4, packet_in_b6,
    output ready
  );
endinterface

interface dfp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [dfp_pkg::ACT_W-1:0]     action;
  logic [dfp_pkg::BYTE_W-1:0]    packet_out_b1;
  logic [dfp_pkg::BYTE_W-1:0]    packet_out_b2;
  logic [dfp_pkg::BYTE_W-1:0]    packet_out_b3;
  logic [dfp_pkg::BYTE_W-1:0]    packet_out_b4;
  logic [dfp_pkg::BYTE_W-1:0]    packet_out_b6;
  logic [dfp_pkg::MASK_W-1:0]    packet_write_mask;
  logic [dfp_pkg::BCD_W-1:0]     version_bcd;
  logic [dfp_pkg::BYTE_W-1:0]    heartbeat_now;
  logic                          field_seen_now;

  modport source (
    output valid, status, action, packet_out_b1, packet_out_b2, packet_out_b3,
           packet_out_b4, packet_out_b6, packet_write_mask, version_bcd,
           heartbeat_now, field_seen_now,
    input  ready
  );
  modport sink (
    input  valid, status, action, packet_out_b1, packet_out_b2, packet_out_b3,
           packet_out_b4, packet_out_b6, packet_write_mask, version_bcd,
           heartbeat_now, field_seen_now,
    output ready
  );
endinterface

### rtl/core/dock_frame_planner.sv
// dock frame planner top level: input register, planning logic, result register, apb registers
// depends on dfp_pkg, dfp_in_if / dfp_out_if and assert_macros.svh
//
// The planner takes one received mailbox frame header per request and returns exactly one
// plan per request: status, dock action, the control packet bytes to write with their mask,
// and the stored version, heartbeat and field-seen state after that frame. A new request is
// accepted in every cycle in which the input register is empty or moves on. A request passes
// from the input register, which holds it with the decimal quotients of its version fields,
// through the planning logic, which updates the dock state and loads the result register,
// and its plan is offered on the result channel. The rate is one request per cycle as long as
// the result side takes plans; when it stalls, both registers fill and then the input side
// stalls. The user must write registers over the apb port only while the planner is idle; the
// planner does not enforce this. There is no clearing pass after reset.
`include "assert_macros.svh"

module dock_frame_planner (
  input  logic                              clk,
  input  logic                              rst_n,
  dfp_in_if.sink                            in_ch,
  dfp_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dfp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [dfp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [dfp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  // decoded request held in the input register
  typedef struct packed {
    logic                        id_frame;
    logic                        charge_frame;
    logic                        pkt_short;
    logic [3:0]                  rel_q0;
    logic [3:0]                  rel_q1;
    logic [3:0]                  rel_q2;
    logic [3:0]                  rel_q3;
    logic [3:0]                  bld_q0;
    logic [3:0]                  bld_q1;
    logic [3:0]                  bld_q2;
    logic [3:0]                  bld_q3;
    logic [3:0]                  bld_q4;
    logic [dfp_pkg::BYTE_W-1:0]  accessory;
    logic [dfp_pkg::BYTE_W-1:0]  mailbox;
    logic [dfp_pkg::BYTE_W-1:0]  b4;
    logic [dfp_pkg::BYTE_W-1:0]  b6;
  } stage_t;

  // plan held in the result register
  typedef struct packed {
    logic                        status;
    dfp_pkg::action_t            action;
    logic [dfp_pkg::BYTE_W-1:0]  b1;
    logic [dfp_pkg::BYTE_W-1:0]  b2;
    logic [dfp_pkg::BYTE_W-1:0]  b3;
    logic [dfp_pkg::BYTE_W-1:0]  b4;
    logic [dfp_pkg::BYTE_W-1:0]  b6;
    logic [dfp_pkg::MASK_W-1:0]  mask;
  } plan_t;

  // configuration registers
  logic [dfp_pkg::BYTE_W-1:0] ready_code_r;
  logic [dfp_pkg::BYTE_W-1:0] advertised_r;
  logic [dfp_pkg::BYTE_W-1:0] hb_limit_r;
  logic [dfp_pkg::BYTE_W-1:0] threshold_r;
  logic [dfp_pkg::BYTE_W-1:0] delay_long_r;
  logic [dfp_pkg::BYTE_W-1:0] delay_short_r;
  logic [dfp_pkg::BYTE_W-1:0] adc_ref_r;

  // dock state
  logic [dfp_pkg::BYTE_W-1:0] heartbeat_r,  heartbeat_nxt;
  logic [dfp_pkg::BYTE_W-1:0] marker_r,     marker_nxt;
  logic [dfp_pkg::BYTE_W-1:0] cached_r,     cached_nxt;
  logic [dfp_pkg::BCD_W-1:0]  version_r,    version_nxt;
  logic [dfp_pkg::BYTE_W-1:0] accessory_r,  accessory_nxt;
  logic                       seen_r,       seen_nxt;

  // pipeline registers
  logic   s1_v_r;
  stage_t s1_r, s1_nxt;
  logic   out_v_r;
  plan_t  plan_r, plan_nxt;

  logic   advance;
  logic   in_take;
  logic   cfg_wr;
  dfp_pkg::reg_idx_t cfg_idx;

  // handshake: the input register moves on whenever the result register is free or drains
  assign advance     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // request decode and decimal quotients ahead of the input register
  always_comb begin
    s1_nxt.id_frame     = (in_ch.frame_len >= dfp_pkg::FLEN_W'(dfp_pkg::HEADER_BYTES))
                          && (in_ch.header_word == dfp_pkg::ID_HEADER);
    s1_nxt.charge_frame = (in_ch.frame_len >= dfp_pkg::FLEN_W'(2))
                          && (in_ch.header_word[31:24] == dfp_pkg::SYNC_BYTE)
                          && (in_ch.header_word[23:16] == dfp_pkg::CHARGE_CMD);
    s1_nxt.pkt_short    = in_ch.packet_length < dfp_pkg::BYTE_W'(dfp_pkg::PACKET_BYTES);
    s1_nxt.rel_q0       = in_ch.release_number[3:0];
    s1_nxt.rel_q1       = dfp_pkg::quo10_nib(in_ch.release_number);
    s1_nxt.rel_q2       = dfp_pkg::quo100_nib(in_ch.release_number);
    s1_nxt.rel_q3       = dfp_pkg::quo1000_nib(in_ch.release_number);
    s1_nxt.bld_q0       = in_ch.build_number[3:0];
    s1_nxt.bld_q1       = dfp_pkg::quo10_nib(in_ch.build_number);
    s1_nxt.bld_q2       = dfp_pkg::quo100_nib(in_ch.build_number);
    s1_nxt.bld_q3       = dfp_pkg::quo1000_nib(in_ch.build_number);
    s1_nxt.bld_q4       = dfp_pkg::quo10000_nib(in_ch.build_number);
    s1_nxt.accessory    = in_ch.accessory_byte;
    s1_nxt.mailbox      = in_ch.mbox_ctrl;
    s1_nxt.b4           = in_ch.packet_in_b4;
    s1_nxt.b6           = in_ch.packet_in_b6;
  end

  // planning logic: state update and packet rewrite for the request in the input register
  always_comb begin
    logic [dfp_pkg::BYTE_W-1:0] hb_inc;
    logic [dfp_pkg::BYTE_W-1:0] sampled;
    logic                       big_build;
    logic [dfp_pkg::BCD_W-1:0]  packed_version;

    heartbeat_nxt = heartbeat_r;
    marker_nxt    = marker_r;
    cached_nxt    = cached_r;
    version_nxt   = version_r;
    accessory_nxt = accessory_r;
    seen_nxt      = seen_r;

    plan_nxt        = '0;
    plan_nxt.status = dfp_pkg::STATUS_OK;
    plan_nxt.action = dfp_pkg::ACT_NONE;
    plan_nxt.mask   = dfp_pkg::MASK_NONE;

    hb_inc  = heartbeat_r + 8'd1;
    sampled = {2'b00, s1_r.b4[7:2]};

    // bcd version: three release digits, four build digits (top four when build >= 10000)
    big_build = s1_r.bld_q4 != 4'd0;
    packed_version[27:24] = dfp_pkg::dec_digit(s1_r.rel_q3, s1_r.rel_q2);
    packed_version[23:20] = dfp_pkg::dec_digit(s1_r.rel_q2, s1_r.rel_q1);
    packed_version[19:16] = dfp_pkg::dec_digit(s1_r.rel_q1, s1_r.rel_q0);
    if (big_build) begin
      packed_version[15:12] = s1_r.bld_q4;
      packed_version[11:8]  = dfp_pkg::dec_digit(s1_r.bld_q4, s1_r.bld_q3);
      packed_version[7:4]   = dfp_pkg::dec_digit(s1_r.bld_q3, s1_r.bld_q2);
      packed_version[3:0]   = dfp_pkg::dec_digit(s1_r.bld_q2, s1_r.bld_q1);
    end else begin
      packed_version[15:12] = s1_r.bld_q3;
      packed_version[11:8]  = dfp_pkg::dec_digit(s1_r.bld_q3, s1_r.bld_q2);
      packed_version[7:4]   = dfp_pkg::dec_digit(s1_r.bld_q2, s1_r.bld_q1);
      packed_version[3:0]   = dfp_pkg::dec_digit(s1_r.bld_q1, s1_r.bld_q0);
    end

    if (!s1_r.id_frame) begin
      // other frames can only schedule the charge field
      if (s1_r.charge_frame) begin
        plan_nxt.action = dfp_pkg::ACT_CHARGE;
      end
    end else if (s1_r.pkt_short) begin
      plan_nxt.status = dfp_pkg::STATUS_SHORT;
    end else begin
      heartbeat_nxt = hb_inc;
      version_nxt   = packed_version;
      accessory_nxt = s1_r.accessory;
      seen_nxt      = 1'b1;
      if (s1_r.mailbox == ready_code_r) begin
        plan_nxt.action = dfp_pkg::ACT_SEND;
        if (marker_r != advertised_r) begin
          // one-time advertisement
          plan_nxt.b1   = dfp_pkg::SYNC_BYTE;
          plan_nxt.b2   = dfp_pkg::ADVERT_CMD;
          plan_nxt.b3   = marker_r;
          plan_nxt.mask = dfp_pkg::MASK_ADVERT;
          marker_nxt    = advertised_r;
        end else if (hb_inc <= hb_limit_r) begin
          // cache a short field delay, else restore the cached one
          if (s1_r.b6 < threshold_r) begin
            cached_nxt = s1_r.b6;
          end else begin
            plan_nxt.b6   = cached_r;
            plan_nxt.mask = dfp_pkg::MASK_DELAY;
          end
        end else begin
          // heartbeat packet rebuild
          heartbeat_nxt = '0;
          plan_nxt.b1   = dfp_pkg::SYNC_BYTE;
          plan_nxt.b2   = dfp_pkg::HBEAT_CMD;
          plan_nxt.b3   = '0;
          plan_nxt.b4   = (adc_ref_r < sampled) ? delay_long_r : delay_short_r;
          plan_nxt.mask = dfp_pkg::MASK_REBUILD;
        end
      end
    end
  end

  // pipeline control and dock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      heartbeat_r <= '0;
      marker_r    <= '0;
      cached_r    <= '0;
      version_r   <= '0;
      accessory_r <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r     <= 1'b1;
        heartbeat_r <= heartbeat_nxt;
        marker_r    <= marker_nxt;
        cached_r    <= cached_nxt;
        version_r   <= version_nxt;
        accessory_r <= accessory_nxt;
        seen_r      <= seen_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= s1_nxt;
    end
    if (advance) begin
      plan_r <= plan_nxt;
    end
  end

  // result channel; state fields follow the plan they belong to
  logic [dfp_pkg::BYTE_W-1:0] hb_out_r;
  logic [dfp_pkg::BCD_W-1:0]  version_out_r;
  logic                       seen_out_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      hb_out_r      <= heartbeat_nxt;
      version_out_r <= version_nxt;
      seen_out_r    <= seen_nxt;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.status            = plan_r.status;
  assign out_ch.action            = plan_r.action;
  assign out_ch.packet_out_b1     = plan_r.b1;
  assign out_ch.packet_out_b2     = plan_r.b2;
  assign out_ch.packet_out_b3     = plan_r.b3;
  assign out_ch.packet_out_b4     = plan_r.b4;
  assign out_ch.packet_out_b6     = plan_r.b6;
  assign out_ch.packet_write_mask = plan_r.mask;
  assign out_ch.version_bcd       = version_out_r;
  assign out_ch.heartbeat_now     = hb_out_r;
  assign out_ch.field_seen_now    = seen_out_r;

  // apb register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = dfp_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_code_r  <= dfp_pkg::RST_READY;
      advertised_r  <= dfp_pkg::RST_ADVERTISED;
      hb_limit_r    <= dfp_pkg::RST_HB_LIMIT;
      threshold_r   <= dfp_pkg::RST_THRESHOLD;
      delay_long_r  <= dfp_pkg::RST_LONG;
      delay_short_r <= dfp_pkg::RST_SHORT;
      adc_ref_r     <= dfp_pkg::RST_ADC;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dfp_pkg::REG_READY:      ready_code_r  <= cfg_pwdata[7:0];
        dfp_pkg::REG_ADVERTISED: advertised_r  <= cfg_pwdata[7:0];
        dfp_pkg::REG_HB_LIMIT:   hb_limit_r    <= cfg_pwdata[7:0];
        dfp_pkg::REG_THRESHOLD:  threshold_r   <= cfg_pwdata[7:0];
        dfp_pkg::REG_LONG:       delay_long_r  <= cfg_pwdata[7:0];
        dfp_pkg::REG_SHORT:      delay_short_r <= cfg_pwdata[7:0];
        dfp_pkg::REG_ADC:        adc_ref_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      dfp_pkg::REG_READY:      cfg_prdata = {24'd0, ready_code_r};
      dfp_pkg::REG_ADVERTISED: cfg_prdata = {24'd0, advertised_r};
      dfp_pkg::REG_HB_LIMIT:   cfg_prdata = {24'd0, hb_limit_r};
      dfp_pkg::REG_THRESHOLD:  cfg_prdata = {24'd0, threshold_r};
      dfp_pkg::REG_LONG:       cfg_prdata = {24'd0, delay_long_r};
      dfp_pkg::REG_SHORT:      cfg_prdata = {24'd0, delay_short_r};
      dfp_pkg::REG_ADC:        cfg_prdata = {24'd0, adc_ref_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // a short packet never sends or writes anything
  `DFP_ASSERT_SAME(a_short_no_write, clk, rst_n,
    out_v_r && (plan_r.status == dfp_pkg::STATUS_SHORT),
    (plan_r.action == dfp_pkg::ACT_NONE) && (plan_r.mask == dfp_pkg::MASK_NONE))

  // written bytes only come with a send action
  `DFP_ASSERT_SAME(a_mask_needs_send, clk, rst_n,
    out_v_r && (plan_r.mask != dfp_pkg::MASK_NONE),
    plan_r.action == dfp_pkg::ACT_SEND)

  // a rebuilt heartbeat packet restarts the heartbeat count
  `DFP_ASSERT_SAME(a_rebuild_clears_hb, clk, rst_n,
    out_v_r && (plan_r.mask == dfp_pkg::MASK_REBUILD),
    hb_out_r == '0)

  // a stalled plan blocks the input once the input register is full
  `DFP_ASSERT_SAME(a_full_stalls_input, clk, rst_n,
    s1_v_r && out_v_r && !out_ch.ready,
    !in_ch.ready)

  // field-seen never drops once set
  `DFP_ASSERT_NEXT(a_seen_sticky, clk, rst_n,
    seen_r,
    seen_r)

endmodule

### sim/dock_frame_planner_tb.sv
// self-checking testbench for the dock frame planner: directed and random frame headers
// depends on dfp_pkg, dfp_in_if / dfp_out_if and the dock_frame_planner rtl
// results are predicted in-line and checked field by field against the plan channel
module dock_frame_planner_tb;

  localparam int QUIET_LIMIT = 2000;

  // one frame request, fields at the channel widths
  typedef struct packed {
    logic [dfp_pkg::FLEN_W-1:0] frame_len;
    logic [dfp_pkg::HDR_W-1:0]  header_word;
    logic [dfp_pkg::NUM_W-1:0]  release_number;
    logic [dfp_pkg::NUM_W-1:0]  build_number;
    logic [dfp_pkg::BYTE_W-1:0] accessory_byte;
    logic [dfp_pkg::BYTE_W-1:0] mbox_ctrl;
    logic [dfp_pkg::BYTE_W-1:0] packet_length;
    logic [dfp_pkg::BYTE_W-1:0] packet_in_b4;
    logic [dfp_pkg::BYTE_W-1:0] packet_in_b6;
  } frame_t;

  // one dock plan
  typedef struct packed {
    logic                       status;
    dfp_pkg::action_t           action;
    logic [dfp_pkg::BYTE_W-1:0] b1;
    logic [dfp_pkg::BYTE_W-1:0] b2;
    logic [dfp_pkg::BYTE_W-1:0] b3;
    logic [dfp_pkg::BYTE_W-1:0] b4;
    logic [dfp_pkg::BYTE_W-1:0] b6;
    logic [dfp_pkg::MASK_W-1:0] mask;
    logic [dfp_pkg::BCD_W-1:0]  version;
    logic [dfp_pkg::BYTE_W-1:0] heartbeat;
    logic                       seen;
  } plan_t;

  logic clk;
  logic rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [dfp_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [dfp_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [dfp_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  dfp_in_if  in_ch ();
  dfp_out_if out_ch ();

  dock_frame_planner u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register copy and dock state of the predictor
  logic [dfp_pkg::BYTE_W-1:0] reg_mirror [0:6];
  logic [dfp_pkg::BYTE_W-1:0] dock_heartbeat;
  logic [dfp_pkg::BYTE_W-1:0] dock_marker;
  logic [dfp_pkg::BYTE_W-1:0] dock_cached_delay;
  logic [dfp_pkg::BCD_W-1:0]  dock_ver_bcd;
  logic [dfp_pkg::BYTE_W-1:0] dock_acc_code;
  logic                       dock_seen;

  plan_t expected_plans [$];
  int    mismatches;
  int    quiet_cycles;
  bit    steady_flow;

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // packed bcd version: three release digits, four build digits
  function automatic logic [dfp_pkg::BCD_W-1:0] version_digits(input int unsigned rel,
                                                                input int unsigned bld);
    int unsigned scale;
    logic [dfp_pkg::BCD_W-1:0] v;
    scale = (bld >= 10000) ? 10000 : 1000;
    v = '0;
    v = {v[dfp_pkg::BCD_W-5:0], 4'((rel / 100) % 10)};
    v = {v[dfp_pkg::BCD_W-5:0], 4'((rel / 10) % 10)};
    v = {v[dfp_pkg::BCD_W-5:0], 4'(rel % 10)};
    for (int k = 0; k < 4; k++) begin
      v = {v[dfp_pkg::BCD_W-5:0], 4'((bld / scale) % 10)};
      scale = scale / 10;
    end
    return v;
  endfunction

  // plan for one accepted frame, advancing the dock state
  function automatic plan_t predict_plan(input frame_t f);
    plan_t p;
    logic [dfp_pkg::BYTE_W-1:0] sampled;
    p = '0;
    p.action = dfp_pkg::ACT_NONE;
    p.status = dfp_pkg::STATUS_OK;
    if (!(f.frame_len >= dfp_pkg::HEADER_BYTES && f.header_word == dfp_pkg::ID_HEADER)) begin
      if (f.frame_len >= 2 && f.header_word[31:24] == dfp_pkg::SYNC_BYTE &&
          f.header_word[23:16] == dfp_pkg::CHARGE_CMD)
        p.action = dfp_pkg::ACT_CHARGE;
    end else if (f.packet_length < dfp_pkg::PACKET_BYTES) begin
      p.status = dfp_pkg::STATUS_SHORT;
    end else begin
      dock_heartbeat = dock_heartbeat + 8'd1;
      dock_ver_bcd   = version_digits(f.release_number, f.build_number);
      dock_acc_code  = f.accessory_byte;
      dock_seen      = 1'b1;
      if (f.mbox_ctrl == reg_mirror[dfp_pkg::REG_READY]) begin
        p.action = dfp_pkg::ACT_SEND;
        if (dock_marker != reg_mirror[dfp_pkg::REG_ADVERTISED]) begin
          // one-time advertisement carries the old marker
          p.b1 = dfp_pkg::SYNC_BYTE;
          p.b2 = dfp_pkg::ADVERT_CMD;
          p.b3 = dock_marker;
          p.mask = dfp_pkg::MASK_ADVERT;
          dock_marker = reg_mirror[dfp_pkg::REG_ADVERTISED];
        end else if (dock_heartbeat <= reg_mirror[dfp_pkg::REG_HB_LIMIT]) begin
          // cache a small delay, otherwise restore the cached one
          if (f.packet_in_b6 < reg_mirror[dfp_pkg::REG_THRESHOLD]) begin
            dock_cached_delay = f.packet_in_b6;
          end else begin
            p.b6 = dock_cached_delay;
            p.mask = dfp_pkg::MASK_DELAY;
          end
        end else begin
          // heartbeat packet rebuilt, counter restarts
          sampled = f.packet_in_b4 >> 2;
          dock_heartbeat = '0;
          p.b1 = dfp_pkg::SYNC_BYTE;
          p.b2 = dfp_pkg::HBEAT_CMD;
          p.b3 = '0;
          p.b4 = (reg_mirror[dfp_pkg::REG_ADC] < sampled) ? reg_mirror[dfp_pkg::REG_LONG]
                                                          : reg_mirror[dfp_pkg::REG_SHORT];
          p.mask = dfp_pkg::MASK_REBUILD;
        end
      end
    end
    p.version   = dock_ver_bcd;
    p.heartbeat = dock_heartbeat;
    p.seen      = dock_seen;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 200)
      $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
  endtask

  // apb read of one register, compared with the register copy
  task automatic apb_read_check(input dfp_pkg::reg_idx_t idx);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (cfg_prdata !== {24'd0, reg_mirror[idx]})
      report_mismatch($sformatf("register %s readback", idx.name()), cfg_prdata,
                      {24'd0, reg_mirror[idx]});
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // apb write of one register, then read back
  task automatic apb_write(input dfp_pkg::reg_idx_t idx,
                           input logic [dfp_pkg::BYTE_W-1:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = {24'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    reg_mirror[idx] = val;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    apb_read_check(idx);
  endtask

  task automatic load_registers(input logic [7:0] ready_code, input logic [7:0] marker,
                                input logic [7:0] hb_limit, input logic [7:0] threshold,
                                input logic [7:0] delay_long, input logic [7:0] delay_short,
                                input logic [7:0] adc_ref);
    apb_write(dfp_pkg::REG_READY, ready_code);
    apb_write(dfp_pkg::REG_ADVERTISED, marker);
    apb_write(dfp_pkg::REG_HB_LIMIT, hb_limit);
    apb_write(dfp_pkg::REG_THRESHOLD, threshold);
    apb_write(dfp_pkg::REG_LONG, delay_long);
    apb_write(dfp_pkg::REG_SHORT, delay_short);
    apb_write(dfp_pkg::REG_ADC, adc_ref);
  endtask

  // one frame request, with a random gap ahead of it unless steady flow is set
  task automatic send_frame(input frame_t f);
    int gap;
    gap = 0;
    if (!steady_flow)
      while ($urandom_range(0, 99) < 18) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.frame_len       = f.frame_len;
    in_ch.header_word     = f.header_word;
    in_ch.release_number  = f.release_number;
    in_ch.build_number    = f.build_number;
    in_ch.accessory_byte  = f.accessory_byte;
    in_ch.mbox_ctrl       = f.mbox_ctrl;
    in_ch.packet_length   = f.packet_length;
    in_ch.packet_in_b4    = f.packet_in_b4;
    in_ch.packet_in_b6    = f.packet_in_b6;
    in_ch.valid           = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    expected_plans.push_back(predict_plan(f));
  endtask

  // stop sending and let every plan come back
  task automatic wait_drained;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_plans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic frame_t plain_frame(input logic [dfp_pkg::FLEN_W-1:0] flen,
                                         input logic [dfp_pkg::HDR_W-1:0] hdr);
    frame_t f;
    f = '0;
    f.frame_len   = flen;
    f.header_word = hdr;
    return f;
  endfunction

  function automatic frame_t id_frame(input logic [7:0] plen, input logic [7:0] mbox,
                                      input logic [7:0] b4, input logic [7:0] b6,
                                      input logic [15:0] rel, input logic [15:0] bld);
    frame_t f;
    f = plain_frame(9'($urandom_range(dfp_pkg::HEADER_BYTES, 256)), dfp_pkg::ID_HEADER);
    f.packet_length   = plen;
    f.mbox_ctrl       = mbox;
    f.packet_in_b4    = b4;
    f.packet_in_b6    = b6;
    f.release_number  = rel;
    f.build_number    = bld;
    f.accessory_byte  = 8'($urandom);
    return f;
  endfunction

  // identity frames with random content, charge frames and noise
  function automatic frame_t random_frame(input int id_pct);
    frame_t f;
    int pick;
    f.frame_len       = 9'($urandom_range(0, 256));
    f.header_word     = $urandom;
    f.release_number  = 16'($urandom);
    f.build_number    = $urandom_range(0, 1) ? 16'($urandom_range(0, 9999)) : 16'($urandom);
    f.accessory_byte  = 8'($urandom);
    f.mbox_ctrl       = 8'($urandom);
    f.packet_length   = 8'($urandom);
    f.packet_in_b4    = 8'($urandom);
    f.packet_in_b6    = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < id_pct) begin
      f.frame_len   = 9'($urandom_range(dfp_pkg::HEADER_BYTES, 256));
      f.header_word = dfp_pkg::ID_HEADER;
      if ($urandom_range(0, 9) == 0)
        f.packet_length = 8'($urandom_range(0, dfp_pkg::PACKET_BYTES - 1));
      else
        f.packet_length = 8'($urandom_range(dfp_pkg::PACKET_BYTES, 255));
      if ($urandom_range(0, 3) != 0) f.mbox_ctrl = reg_mirror[dfp_pkg::REG_READY];
      // values around the delay threshold and the reference level
      if ($urandom_range(0, 2) == 0)
        f.packet_in_b6 = reg_mirror[dfp_pkg::REG_THRESHOLD] + 8'($urandom_range(0, 2)) - 8'd1;
      if ($urandom_range(0, 2) == 0)
        f.packet_in_b4 = {reg_mirror[dfp_pkg::REG_ADC][5:0], 2'b00} + 8'($urandom_range(0, 7));
    end else if (pick < id_pct + (100 - id_pct) / 2) begin
      f.header_word[31:16] = {dfp_pkg::SYNC_BYTE, dfp_pkg::CHARGE_CMD};
      if ($urandom_range(0, 7) == 0) f.frame_len = 9'($urandom_range(0, 1));
    end else if ($urandom_range(0, 3) == 0) begin
      // identity header on a frame too short to hold it
      f.header_word = dfp_pkg::ID_HEADER;
      f.frame_len   = 9'($urandom_range(0, dfp_pkg::HEADER_BYTES - 1));
    end
    return f;
  endfunction

  // registers read back their reset values
  task automatic test_register_reset;
    apb_read_check(dfp_pkg::REG_READY);
    apb_read_check(dfp_pkg::REG_ADVERTISED);
    apb_read_check(dfp_pkg::REG_HB_LIMIT);
    apb_read_check(dfp_pkg::REG_THRESHOLD);
    apb_read_check(dfp_pkg::REG_LONG);
    apb_read_check(dfp_pkg::REG_SHORT);
    apb_read_check(dfp_pkg::REG_ADC);
  endtask

  // charge detection, short frames, near misses, short packets
  task automatic test_frame_decode;
    logic [7:0] rdy;
    rdy = reg_mirror[dfp_pkg::REG_READY];
    send_frame(plain_frame(9'd0, {dfp_pkg::SYNC_BYTE, dfp_pkg::CHARGE_CMD, 16'h0000}));
    send_frame(plain_frame(9'd1, {dfp_pkg::SYNC_BYTE, dfp_pkg::CHARGE_CMD, 16'hFFFF}));
    send_frame(plain_frame(9'd2, {dfp_pkg::SYNC_BYTE, dfp_pkg::CHARGE_CMD, 16'h0000}));
    send_frame(plain_frame(9'd256, {dfp_pkg::SYNC_BYTE, dfp_pkg::CHARGE_CMD, 16'hFFFF}));
    send_frame(plain_frame(9'd256, {dfp_pkg::SYNC_BYTE, 8'h05, 16'h0000}));
    send_frame(plain_frame(9'(dfp_pkg::HEADER_BYTES - 1), dfp_pkg::ID_HEADER));
    send_frame(plain_frame(9'd256, dfp_pkg::ID_HEADER ^ 32'h1));
    send_frame(id_frame(8'd0, rdy, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_frame(id_frame(8'(dfp_pkg::PACKET_BYTES - 1), rdy, 8'h00, 8'h00,
                        16'h0000, 16'h0000));
    wait_drained();
  endtask

  // not ready, advertisement, delay cache and restore, packet rebuild
  task automatic test_identity_paths;
    logic [7:0] rdy;
    logic [7:0] thr;
    logic [7:0] plen;
    apb_write(dfp_pkg::REG_LONG, 8'h5A);
    apb_write(dfp_pkg::REG_SHORT, 8'hA5);
    rdy  = reg_mirror[dfp_pkg::REG_READY];
    thr  = reg_mirror[dfp_pkg::REG_THRESHOLD];
    plen = 8'(dfp_pkg::PACKET_BYTES);
    send_frame(id_frame(plen, rdy + 8'd1, 8'h00, 8'h00, 16'd0, 16'd0));
    send_frame(id_frame(8'd255, rdy, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF));
    send_frame(id_frame(plen, rdy, 8'h00, 8'h00, 16'd999, 16'd9999));
    send_frame(id_frame(plen, rdy, 8'h00, thr - 8'd1, 16'd0, 16'd0));
    send_frame(id_frame(plen, rdy, 8'h00, thr, 16'd123, 16'd10000));
    send_frame(id_frame(plen, rdy, 8'h00, 8'hFF, 16'd1000, 16'd10000));
    repeat (4)
      send_frame(id_frame(plen, rdy, 8'($urandom), 8'hFF, 16'($urandom), 16'($urandom)));
    wait_drained();
    // every ready frame now rebuilds the heartbeat packet
    apb_write(dfp_pkg::REG_HB_LIMIT, 8'd0);
    send_frame(id_frame(plen, rdy, 8'hFF, 8'h00, 16'd1, 16'd2));
    send_frame(id_frame(plen, rdy, 8'h03, 8'h00, 16'd3, 16'd4));
    send_frame(id_frame(plen, rdy, 8'h04, 8'h00, 16'd5, 16'd6));
    wait_drained();
  endtask

  // random traffic under the current register setting
  task automatic test_random_traffic(input int count, input int id_pct, input int steady);
    for (int n = 0; n < count; n++) begin
      steady_flow = (n < steady);
      send_frame(random_frame(id_pct));
    end
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // receiver stalls at random unless steady flow is set
  always @(negedge clk) begin
    if (steady_flow) out_ch.ready = 1'b1;
    else out_ch.ready = ($urandom_range(0, 99) >= 18);
  end

  // plan checker
  always @(posedge clk) begin
    plan_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_plans.size() == 0) begin
        report_mismatch("plan with no request pending", out_ch.action, 0);
      end else begin
        want = expected_plans.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.action !== want.action)
          report_mismatch("action", out_ch.action, want.action);
        if (out_ch.packet_out_b1 !== want.b1)
          report_mismatch("packet_out_b1", out_ch.packet_out_b1, want.b1);
        if (out_ch.packet_out_b2 !== want.b2)
          report_mismatch("packet_out_b2", out_ch.packet_out_b2, want.b2);
        if (out_ch.packet_out_b3 !== want.b3)
          report_mismatch("packet_out_b3", out_ch.packet_out_b3, want.b3);
        if (out_ch.packet_out_b4 !== want.b4)
          report_mismatch("packet_out_b4", out_ch.packet_out_b4, want.b4);
        if (out_ch.packet_out_b6 !== want.b6)
          report_mismatch("packet_out_b6", out_ch.packet_out_b6, want.b6);
        if (out_ch.packet_write_mask !== want.mask)
          report_mismatch("packet_write_mask", out_ch.packet_write_mask, want.mask);
        if (out_ch.version_bcd !== want.version)
          report_mismatch("version_bcd", out_ch.version_bcd, want.version);
        if (out_ch.heartbeat_now !== want.heartbeat)
          report_mismatch("heartbeat_now", out_ch.heartbeat_now, want.heartbeat);
        if (out_ch.field_seen_now !== want.seen)
          report_mismatch("field_seen_now", out_ch.field_seen_now, want.seen);
      end
    end
  end

  // cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("dock_frame_planner verification failed");
    $finish;
  end

  // test sequence
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.frame_len = '0;
    in_ch.header_word = '0;
    in_ch.release_number = '0;
    in_ch.build_number = '0;
    in_ch.accessory_byte = '0;
    in_ch.mbox_ctrl = '0;
    in_ch.packet_length = '0;
    in_ch.packet_in_b4 = '0;
    in_ch.packet_in_b6 = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    steady_flow = 1'b0;
    reg_mirror[dfp_pkg::REG_READY]      = dfp_pkg::RST_READY;
    reg_mirror[dfp_pkg::REG_ADVERTISED] = dfp_pkg::RST_ADVERTISED;
    reg_mirror[dfp_pkg::REG_HB_LIMIT]   = dfp_pkg::RST_HB_LIMIT;
    reg_mirror[dfp_pkg::REG_THRESHOLD]  = dfp_pkg::RST_THRESHOLD;
    reg_mirror[dfp_pkg::REG_LONG]       = dfp_pkg::RST_LONG;
    reg_mirror[dfp_pkg::REG_SHORT]      = dfp_pkg::RST_SHORT;
    reg_mirror[dfp_pkg::REG_ADC]        = dfp_pkg::RST_ADC;
    dock_heartbeat = '0;
    dock_marker = '0;
    dock_cached_delay = '0;
    dock_ver_bcd = '0;
    dock_acc_code = '0;
    dock_seen = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_register_reset();
    test_frame_decode();
    test_identity_paths();
    // default-like setting, opening with a stretch of full-rate traffic
    load_registers(8'h00, 8'h01, 8'd10, 8'd128, 8'h5A, 8'hA5, 8'd20);
    test_random_traffic(200, 60, 100);
    // low extremes of limits, high reference
    load_registers(8'hFF, 8'h00, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
    test_random_traffic(150, 60, 0);
    // high limits, mostly identity frames so the heartbeat wraps
    load_registers(8'h00, 8'hFF, 8'd255, 8'd255, 8'h00, 8'hFF, 8'h00);
    test_random_traffic(350, 95, 0);
    // random setting
    load_registers(8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom_range(0, 63)));
    test_random_traffic(150, 60, 0);

    if (mismatches == 0) $display("dock_frame_planner verification clean");
    else $display("dock_frame_planner verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dfp_pkg.sv
rtl/core/dfp_if.sv
rtl/core/dock_frame_planner.sv
sim/dock_frame_planner_tb.sv
